FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/trs_pkg.sv
// Types and constants of the threshold resizing stack.
`timescale 1ns / 1ps
package trs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_PCT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_PCT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_SHIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CAP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP     = 3'd5;

  localparam logic [6:0]  FULL_PCT_RST     = 7'd85;
  localparam logic [6:0]  EMPTY_PCT_RST    = 7'd15;
  localparam logic [1:0]  GROW_SHIFT_RST   = 2'd1;
  localparam logic [1:0]  SHRINK_SHIFT_RST = 2'd1;
  localparam logic [10:0] MIN_CAP_RST      = 11'd10;
  localparam logic [10:0] INIT_CAP_RST     = 11'd10;

  localparam int unsigned PCT_SCALE = 100;

  localparam logic signed [31:0] UNDERFLOW_VALUE = -32'sd99;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    RS_NONE   = 2'd0,
    RS_GREW   = 2'd1,
    RS_SHRANK = 2'd2
  } resize_e;

  typedef struct packed {
    logic [6:0]  full_pct;
    logic [6:0]  empty_pct;
    logic [1:0]  grow_shift;
    logic [1:0]  shrink_shift;
    logic [10:0] min_capacity;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic               underflow;
    logic               overflow;
    logic [1:0]         resized;
    logic [10:0]        current_capacity;
    logic [10:0]        entry_count;
    logic [10:0]        peak_capacity;
    logic [15:0]        resize_total;
    logic [31:0]        operation_total;
  } out_word_t;

endpackage

FILE: rtl/trs_resize.sv
// Capacity policy: threshold compare and grow or shrink of the logical capacity.
`timescale 1ns / 1ps
module trs_resize #(
  parameter int unsigned MAX_DEPTH = 1024,
  localparam int unsigned CW = $clog2(MAX_DEPTH + 1)
) (
  input  trs_pkg::cfg_t    cfg_i,
  input  logic [CW-1:0]    cap_i,
  input  logic [CW-1:0]    held_i,
  output logic [CW-1:0]    cap_o,
  output trs_pkg::resize_e kind_o
);

  localparam int unsigned LW = CW + 8;
  localparam int unsigned GW = CW + 3;
  localparam int unsigned MW = (CW > 11) ? CW : 11;

  logic signed [LW-1:0] top_s;
  logic signed [LW-1:0] lhs;
  logic signed [LW-1:0] full_rhs;
  logic signed [LW-1:0] empty_rhs;
  logic [GW-1:0]        grow_n;
  logic [CW-1:0]        grow_cap;
  logic [CW-1:0]        shr_n;
  logic [CW-1:0]        shr_cap;
  logic                 above_min;

  always_comb begin
    top_s     = $signed(LW'(held_i)) - $signed(LW'(1));
    lhs       = top_s * $signed(LW'(trs_pkg::PCT_SCALE));
    full_rhs  = $signed(LW'(cfg_i.full_pct) * LW'(cap_i));
    empty_rhs = $signed(LW'(cfg_i.empty_pct) * LW'(cap_i));

    grow_n = GW'(cap_i) << cfg_i.grow_shift;
    if (grow_n > GW'(MAX_DEPTH)) begin
      grow_cap = CW'(MAX_DEPTH);
    end else begin
      grow_cap = grow_n[CW-1:0];
    end

    shr_n = cap_i >> cfg_i.shrink_shift;
    if (shr_n == '0) begin
      shr_cap = CW'(1);
    end else begin
      shr_cap = shr_n;
    end

    above_min = MW'(cap_i) > MW'(cfg_i.min_capacity);

    priority if (lhs > full_rhs) begin
      cap_o  = grow_cap;
      kind_o = trs_pkg::RS_GREW;
    end else if ((lhs < empty_rhs) && above_min) begin
      cap_o  = shr_cap;
      kind_o = trs_pkg::RS_SHRANK;
    end else begin
      cap_o  = cap_i;
      kind_o = trs_pkg::RS_NONE;
    end
  end

endmodule

FILE: rtl/threshold_resizing_stack.sv
// Top level of the threshold resizing stack: memory, state, counters and result register.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+------------------------------
//  command   | start, busy, in_word_i                 | taken when start && !busy
//  result    | done_o, result_o                       | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | written when cfg_we_i is high
//
// The word of every command is on result_o in the cycle after it is taken.
// A new command can be taken in every cycle; busy is always low.
// The memory read of a pop is registered at the same edge that takes the command.
// Reset clears the control state and the counters; the stack memory is not cleared.
`timescale 1ns / 1ps
module threshold_resizing_stack #(
  parameter int unsigned MAX_DEPTH  = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  trs_pkg::in_word_t                  in_word_i,
  output logic                               done_o,
  output trs_pkg::out_word_t                 result_o,
  input  logic                               cfg_we_i,
  input  logic [trs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned MW = (CW > 11) ? CW : 11;

  trs_pkg::cfg_t      cfg_q, cfg_d;
  logic [CW-1:0]      held_q, held_d;
  logic [CW-1:0]      cap_q, cap_d;
  logic [CW-1:0]      peak_q, peak_d;
  logic [15:0]        rsz_cnt_q, rsz_cnt_d;
  logic [31:0]        op_cnt_q, op_cnt_d;
  logic               done_q;
  logic               pop_ok_q;
  trs_pkg::out_word_t res_q, res_d;
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];

  logic               accept;
  logic               is_pop;
  logic               push_ok;
  logic               pop_ok;
  logic [CW-1:0]      held_dec;
  logic [CW-1:0]      rs_cap;
  trs_pkg::resize_e   rs_kind;
  logic [CW-1:0]      init_cap;
  logic [DATA_WIDTH-1:0] wdata;

  trs_resize #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_resize (
    .cfg_i (cfg_q),
    .cap_i (cap_q),
    .held_i(held_q),
    .cap_o (rs_cap),
    .kind_o(rs_kind)
  );

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_pop   = in_word_i.opcode == trs_pkg::OP_POP;
  assign push_ok  = accept && !is_pop && (held_q < CW'(MAX_DEPTH));
  assign pop_ok   = accept && is_pop && (held_q != '0);
  assign held_dec = held_q - CW'(1);
  assign wdata    = DATA_WIDTH'($unsigned(in_word_i.push_value));

  always_comb begin
    if (cfg_wdata_i == '0) begin
      init_cap = CW'(1);
    end else if (MW'(cfg_wdata_i) > MW'(MAX_DEPTH)) begin
      init_cap = CW'(MAX_DEPTH);
    end else begin
      init_cap = CW'(cfg_wdata_i);
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    cap_d = cap_q;
    if (accept) begin
      cap_d = rs_cap;
    end
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trs_pkg::CFG_FULL_PCT:     cfg_d.full_pct     = cfg_wdata_i[6:0];
        trs_pkg::CFG_EMPTY_PCT:    cfg_d.empty_pct    = cfg_wdata_i[6:0];
        trs_pkg::CFG_GROW_SHIFT:   cfg_d.grow_shift   = cfg_wdata_i[1:0];
        trs_pkg::CFG_SHRINK_SHIFT: cfg_d.shrink_shift = cfg_wdata_i[1:0];
        trs_pkg::CFG_MIN_CAP:      cfg_d.min_capacity = cfg_wdata_i;
        trs_pkg::CFG_INIT_CAP:     cap_d              = init_cap;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_d = held_q;
    if (push_ok) begin
      held_d = held_q + CW'(1);
    end else if (pop_ok) begin
      held_d = held_dec;
    end

    peak_d = peak_q;
    if (accept && (rs_kind == trs_pkg::RS_GREW) && (rs_cap > peak_q)) begin
      peak_d = rs_cap;
    end

    rsz_cnt_d = rsz_cnt_q;
    if (accept && (rs_kind != trs_pkg::RS_NONE) && (rsz_cnt_q != '1)) begin
      rsz_cnt_d = rsz_cnt_q + 16'd1;
    end

    op_cnt_d = op_cnt_q;
    if ((push_ok || pop_ok) && (op_cnt_q != '1)) begin
      op_cnt_d = op_cnt_q + 32'd1;
    end

    res_d                  = '0;
    res_d.underflow        = is_pop && !pop_ok;
    res_d.overflow         = !is_pop && !push_ok;
    res_d.pop_value        = res_d.underflow ? trs_pkg::UNDERFLOW_VALUE : '0;
    res_d.resized          = rs_kind;
    res_d.current_capacity = 11'(rs_cap);
    res_d.entry_count      = 11'(held_d);
    res_d.peak_capacity    = 11'(peak_d);
    res_d.resize_total     = rsz_cnt_d;
    res_d.operation_total  = op_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_pct     <= trs_pkg::FULL_PCT_RST;
      cfg_q.empty_pct    <= trs_pkg::EMPTY_PCT_RST;
      cfg_q.grow_shift   <= trs_pkg::GROW_SHIFT_RST;
      cfg_q.shrink_shift <= trs_pkg::SHRINK_SHIFT_RST;
      cfg_q.min_capacity <= trs_pkg::MIN_CAP_RST;
      cap_q              <= CW'(trs_pkg::INIT_CAP_RST);
      held_q             <= '0;
      peak_q             <= '0;
      rsz_cnt_q          <= '0;
      op_cnt_q           <= '0;
      done_q             <= 1'b0;
      pop_ok_q           <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      cap_q    <= cap_d;
      held_q   <= held_d;
      peak_q   <= peak_d;
      rsz_cnt_q <= rsz_cnt_d;
      op_cnt_q <= op_cnt_d;
      done_q   <= accept;
      pop_ok_q <= pop_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[held_q[AW-1:0]] <= wdata;
    end
    if (pop_ok) begin
      rd_q <= mem[held_dec[AW-1:0]];
    end
  end

  always_comb begin
    result_o = res_q;
    if (pop_ok_q) begin
      result_o.pop_value = 32'($signed(rd_q));
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/trs_checker.sv
// Port checker of the threshold resizing stack and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input trs_pkg::out_word_t result_o
);

  `ASSERT_NEXT(a_done_after_take, clk_i, rst_ni, start && !busy, done_o)
  `ASSERT_NEXT(a_no_stray_done, clk_i, rst_ni, !(start && !busy), !done_o)
  `ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, done_o, !(result_o.underflow && result_o.overflow))
  `ASSERT_NOW(a_underflow_word, clk_i, rst_ni, done_o && result_o.underflow, result_o.pop_value == trs_pkg::UNDERFLOW_VALUE)
  `ASSERT_NOW(a_resizes_grow, clk_i, rst_ni, done_o && $past(done_o), result_o.resize_total >= $past(result_o.resize_total))

endmodule

bind threshold_resizing_stack trs_checker u_trs_checker (.*);
